[sv/lcg_bounded_random_core_assert.svh]
// ----------------------------------------------------------------------------
// lcg_bounded_random_core_assert.svh
// Assertion macros shared by the LCG bounded random checker.
// ----------------------------------------------------------------------------
`ifndef LCG_BOUNDED_RANDOM_CORE_ASSERT_SVH
`define LCG_BOUNDED_RANDOM_CORE_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define LBR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lcgbr_pkg.sv]
// ----------------------------------------------------------------------------
// lcgbr_pkg
// Shared constants and types of the LCG bounded random core.
// ----------------------------------------------------------------------------
package lcgbr_pkg;

    localparam int          SEED_W    = 32;
    localparam int          RANGE_W   = 17;
    localparam int          VALUE_W   = 16;
    localparam int          DIV_STEPS = VALUE_W;
    localparam int          CNT_W     = $clog2(DIV_STEPS);

    localparam logic [SEED_W-1:0] LCG_MULT   = 32'd1194211693;
    localparam logic [SEED_W-1:0] LCG_ADD    = 32'd12345;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

    // controller -> datapath
    typedef struct packed {
        logic load_range;
        logic mul;
        logic add;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bypass;
        logic div_last;
    } t_dp_sts;

endpackage

[sv/lcgbr_dp.sv]
// ----------------------------------------------------------------------------
// lcgbr_dp
// Datapath: seed register, LCG multiply/add, restoring remainder unit and
// output data register.
// ----------------------------------------------------------------------------
module lcgbr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_seed_we,
    input  logic [lcgbr_pkg::SEED_W-1:0]  i_seed_wdata,
    input  logic [lcgbr_pkg::RANGE_W-1:0] i_range_n,
    input  lcgbr_pkg::t_dp_cmd            i_cmd,
    output lcgbr_pkg::t_dp_sts            o_sts,
    output logic [lcgbr_pkg::VALUE_W-1:0] o_random_value
);
    import lcgbr_pkg::*;

    logic [SEED_W-1:0]  r_seed, n_seed;
    logic [SEED_W-1:0]  r_prod;
    logic [VALUE_W-1:0] r_range;
    logic               r_bypass;
    logic [VALUE_W-1:0] r_dvd, n_dvd;
    logic [VALUE_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_out, n_out;

    logic [SEED_W-1:0]  sum;
    logic [VALUE_W:0]   rem_sh;
    logic               ge;

    assign sum    = r_prod + LCG_ADD;
    assign rem_sh = {r_rem, r_dvd[VALUE_W-1]};
    assign ge     = rem_sh >= {1'b0, r_range};

    always_comb begin
        n_seed = r_seed;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_out  = r_out;
        if (i_seed_we) begin
            n_seed = i_seed_wdata;
        end else if (i_cmd.add) begin
            n_seed = sum;
        end
        if (i_cmd.add) begin
            n_dvd = sum[SEED_W-1 -: VALUE_W];
            n_rem = '0;
            n_cnt = '0;
        end else if (i_cmd.div_step) begin
            n_dvd = {r_dvd[VALUE_W-2:0], 1'b0};
            n_rem = ge ? VALUE_W'(rem_sh - {1'b0, r_range}) : rem_sh[VALUE_W-1:0];
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            n_out = r_bypass ? r_seed[SEED_W-1 -: VALUE_W] : r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else begin
            r_seed <= n_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_range) begin
            r_range  <= i_range_n[VALUE_W-1:0];
            // zero, or 65536 and above: raw upper half
            r_bypass <= (i_range_n == '0) || i_range_n[RANGE_W-1];
        end
        if (i_cmd.mul) begin
            r_prod <= r_seed * LCG_MULT;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    assign o_sts.bypass   = r_bypass;
    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_random_value = r_out;

endmodule

[sv/lcgbr_ctrl.sv]
// ----------------------------------------------------------------------------
// lcgbr_ctrl
// Controller: sequences multiply, add, remainder steps and output load,
// and owns the handshake flags.
// ----------------------------------------------------------------------------
module lcgbr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lcgbr_pkg::t_dp_sts i_sts,
    output lcgbr_pkg::t_dp_cmd o_cmd
);
    import lcgbr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ADD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.load_range = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = i_sts.bypass ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_FIN;
            end
            S_FIN: begin
                // wait here while the previous result is still unclaimed
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[sv/lcg_bounded_random_core.sv]
// ----------------------------------------------------------------------------
// lcg_bounded_random_core
// 32-bit LCG (seed = 1194211693*seed + 12345) with a bounded 16-bit result.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_in_valid / o_in_ready carry i_range_n. Response channel:
//   o_out_valid / i_out_ready carry o_random_value, the upper 16 bits of the
//   advanced seed modulo i_range_n (raw upper bits for 0 or >= 65536).
//   i_seed_we / i_seed_wdata load the running seed directly; write only while
//   no request is in flight.
//   A bounded range runs a multiply, an add, 16 restoring remainder steps
//   and an output load; the raw cases skip the remainder steps.
//   One request is taken at a time, a new one in the cycle after the
//   previous has reached the output register.
//   A finished result waits in the output register; if the receiver stalls,
//   the next request still runs and then holds until the register frees.
//   Reset (synchronous, active low) sets the seed to 1 and drops o_out_valid.
// ----------------------------------------------------------------------------
module lcg_bounded_random_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_seed_we,
    input  logic [lcgbr_pkg::SEED_W-1:0]  i_seed_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lcgbr_pkg::RANGE_W-1:0] i_range_n,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lcgbr_pkg::VALUE_W-1:0] o_random_value
);
    import lcgbr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    lcgbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lcgbr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (i_seed_we),
        .i_seed_wdata   (i_seed_wdata),
        .i_range_n      (i_range_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_random_value (o_random_value)
    );

endmodule

[sv/lcgbr_checker.sv]
// ----------------------------------------------------------------------------
// lcgbr_checker
// Port-level checks of the LCG bounded random core, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcg_bounded_random_core_assert.svh"

module lcgbr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [lcgbr_pkg::RANGE_W-1:0] i_range_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [lcgbr_pkg::VALUE_W-1:0] o_random_value
);
    import lcgbr_pkg::*;

    logic               in_acc, out_acc;
    logic [RANGE_W-1:0] r_last_range;
    logic [1:0]         r_pending;
    logic               r_out_valid_d, r_out_ready_d;
    logic               out_load;
    logic               bounded_ok;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_range  <= '0;
            r_pending     <= '0;
            r_out_valid_d <= 1'b0;
            r_out_ready_d <= 1'b0;
        end else begin
            if (in_acc) r_last_range <= i_range_n;
            r_pending     <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
            r_out_valid_d <= o_out_valid;
            r_out_ready_d <= i_out_ready;
        end
    end

    // a fresh result appears in the output register
    assign out_load   = o_out_valid && (!r_out_valid_d || r_out_ready_d);
    // the loaded result always belongs to the latest request
    assign bounded_ok = (r_last_range == '0) || r_last_range[RANGE_W-1] ||
                        (o_random_value < r_last_range[VALUE_W-1:0]);

    `LBR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_random_value), "stalled response changed")
    `LBR_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_in_ready,
        "request taken while previous still in work")
    `LBR_ASSERT_NOW(a_result_in_range, out_load, bounded_ok,
        "result not below requested range")
    `LBR_ASSERT_NOW(a_pending_bound, 1'b1, r_pending <= 2'd2,
        "more than two requests outstanding")

endmodule

bind lcg_bounded_random_core lcgbr_checker u_lcgbr_checker (.*);

[verif/tb_lcg_bounded_random_core.sv]
// ----------------------------------------------------------------------------
// tb_lcg_bounded_random_core
// Self-checking bench for the LCG bounded random core: a directed table of
// requests and seed loads, then random ranges under three pacing schemes,
// each response compared in order against a cycle-free model of the
// generator or the expected value given in a directed row.
// ----------------------------------------------------------------------------
module tb_lcg_bounded_random_core;

    timeunit 1ns;
    timeprecision 1ps;

    import lcgbr_pkg::*;

    localparam logic [31:0]        MULTIPLIER  = 32'd1194211693;
    localparam logic [31:0]        INCREMENT   = 32'd12345;
    localparam logic [RANGE_W-1:0] FULL_SPAN   = 17'd65536;
    localparam int                 SETTLE      = 4;
    localparam int                 TAIL_CYCLES = 25;
    localparam int                 STALL_LIMIT = 2000;
    localparam int                 N_CHUNKS    = 6;
    localparam int                 CHUNK_REQS  = 89;
    localparam int                 N_DIRECTED  = 23;

    typedef enum logic {ROW_REQ, ROW_SEED} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] value;     // range for a request, seed for a load
        bit          typed;     // expected value given in the row
        logic [15:0] want;
    } t_stim_row;

    // seed 1 after reset: first advanced seed is 1194224038, upper half 18222
    // seed 0: first advanced seed is 12345, upper half 0
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{ROW_REQ,  32'd0,        1'b1, 16'd18222},
        '{ROW_REQ,  32'd1,        1'b1, 16'd0},
        '{ROW_REQ,  32'd65536,    1'b0, 16'd0},
        '{ROW_REQ,  32'd65535,    1'b0, 16'd0},
        '{ROW_REQ,  32'd2,        1'b0, 16'd0},
        '{ROW_REQ,  32'd3,        1'b0, 16'd0},
        '{ROW_REQ,  32'h5555,     1'b0, 16'd0},
        '{ROW_REQ,  32'hAAAA,     1'b0, 16'd0},
        '{ROW_REQ,  32'd32768,    1'b0, 16'd0},
        '{ROW_REQ,  32'd65534,    1'b0, 16'd0},
        '{ROW_SEED, 32'd0,        1'b0, 16'd0},
        '{ROW_REQ,  32'd5,        1'b1, 16'd0},
        '{ROW_REQ,  32'd0,        1'b0, 16'd0},
        '{ROW_SEED, 32'hFFFFFFFF, 1'b0, 16'd0},
        '{ROW_REQ,  32'd0,        1'b0, 16'd0},
        '{ROW_REQ,  32'd65536,    1'b0, 16'd0},
        '{ROW_REQ,  32'd100,      1'b0, 16'd0},
        '{ROW_SEED, 32'h80000000, 1'b0, 16'd0},
        '{ROW_REQ,  32'd12345,    1'b0, 16'd0},
        '{ROW_SEED, 32'd1,        1'b0, 16'd0},
        '{ROW_REQ,  32'd0,        1'b1, 16'd18222},
        '{ROW_REQ,  32'd1,        1'b1, 16'd0},
        '{ROW_REQ,  32'd7,        1'b0, 16'd0}
    };

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_seed_we    = 1'b0;
    logic [SEED_W-1:0]   i_seed_wdata = '0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [RANGE_W-1:0]  i_range_n    = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [VALUE_W-1:0]  o_random_value;

    logic [31:0]         gen_seed = 32'd1;
    logic [15:0]         pending_values [$];
    int                  tx_idle_pct   = 0;
    int                  rx_idle_pct   = 0;
    int                  request_count = 0;
    int                  result_count  = 0;
    int                  seed_loads    = 0;
    int                  mismatch_count = 0;
    int                  stall_cycles  = 0;

    lcg_bounded_random_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (i_seed_we),
        .i_seed_wdata   (i_seed_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_range_n      (i_range_n),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_random_value (o_random_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // advances the generator and bounds the upper half by the range, raw for 0 or 65536 and above
    function automatic logic [15:0] next_bounded_value(input logic [RANGE_W-1:0] rng);
        logic [15:0]        upper;
        logic [RANGE_W-1:0] rem;
        gen_seed = gen_seed * MULTIPLIER + INCREMENT;
        upper    = gen_seed[31:16];
        if (rng == '0 || rng >= FULL_SPAN) begin
            return upper;
        end
        rem = {1'b0, upper} % rng;
        return rem[15:0];
    endfunction

    function automatic logic [RANGE_W-1:0] pick_range();
        unique case ($urandom_range(0, 7))
            0: return '0;
            1: return FULL_SPAN;
            2: return 17'd1;
            3: return 17'($urandom_range(2, 16));
            4: return 17'($urandom_range(65000, 65535));
            default: return 17'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic report_mismatch(input string line);
        $display("[%0t] %s", $realtime, line);
        mismatch_count++;
    endtask

    // called at a rising edge; holds the request until it is taken
    task automatic send_request(input logic [RANGE_W-1:0] rng, input bit typed,
                                input logic [15:0] want);
        logic [15:0] predicted;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_range_n  <= rng;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = next_bounded_value(rng);
        pending_values.push_back(typed ? want : predicted);
        request_count++;
    endtask

    // sender holds off until every response is back, then waits out the SETTLE margin
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_seed(input logic [31:0] value);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= value;
        @(posedge i_clk);
        i_seed_we    <= 1'b0;
        gen_seed = value;
        seed_loads++;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (pending_values.size() == 0) begin
                report_mismatch($sformatf("response %0d with no request outstanding",
                                          o_random_value));
            end else begin
                want = pending_values.pop_front();
                if (o_random_value !== want) begin
                    report_mismatch($sformatf("random_value: expected %0d, got %0d",
                                              want, o_random_value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                         STALL_LIMIT, pending_values.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int directed_reqs;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 24;
        rx_idle_pct = 48;
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].kind == ROW_SEED) begin
                wait_idle();
                load_seed(directed_rows[i].value);
            end else begin
                send_request(directed_rows[i].value[RANGE_W-1:0], directed_rows[i].typed,
                             directed_rows[i].want);
            end
        end
        directed_reqs = request_count;

        for (int c = 0; c < N_CHUNKS; c++) begin
            if (c < 2) begin
                tx_idle_pct = 24;
                rx_idle_pct = 48;
            end else if (c < 4) begin
                tx_idle_pct = 48;
                rx_idle_pct = 24;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wait_idle();
            load_seed((c == 3) ? 32'd0 : (c == 5) ? 32'hFFFFFFFF : 32'($urandom()));
            for (int k = 0; k < CHUNK_REQS; k++) begin
                send_request(pick_range(), 1'b0, 16'd0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d from the directed table), %0d responses,",
                 request_count, directed_reqs, result_count);
        $display("%0d seed loads, three pacing schemes on both channels",
                 seed_loads);
        if (mismatch_count == 0 && pending_values.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/lcgbr_pkg.sv
sv/lcgbr_dp.sv
sv/lcgbr_ctrl.sv
sv/lcg_bounded_random_core.sv
sv/lcgbr_checker.sv
verif/tb_lcg_bounded_random_core.sv
